>>> src/des_block_encrypt_macros.svh
// Assertion macros shared by the DES encryption block.
// Included by every RTL file that carries concurrent assertions; no other dependencies.
`ifndef DES_BLOCK_ENCRYPT_MACROS_SVH
`define DES_BLOCK_ENCRYPT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define DES_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("DES block assertion failed");
// Checked at every clock edge, reset included.
`define DES_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("DES block assertion failed");
`else
`define DES_ASSERT(label, clk, rst_n, prop)
`define DES_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> src/des_pkg.sv
// Package for the DES encryption block: permutation tables, S-boxes and
// the bit-level functions for the key schedule and the Feistel round. No dependencies.
package des_pkg;

    localparam int BLOCK_BITS      = 64;
    localparam int HALF_BLOCK_BITS = 32;
    localparam int HALF_KEY_BITS   = 28;
    localparam int ROUND_KEY_BITS  = 48;
    localparam int ROUNDS          = 16;

    // Two halves of the block as they travel between round cells.
    typedef struct packed {
        logic [HALF_BLOCK_BITS-1:0] left;
        logic [HALF_BLOCK_BITS-1:0] right;
    } t_halves;

    typedef logic [ROUND_KEY_BITS-1:0] t_round_key;

    localparam logic [7:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam logic [7:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam logic [7:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };

    localparam logic [7:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam logic [7:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4 };

    localparam logic [7:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32 };

    // Total left rotation of C and D reached at each round.
    localparam logic [4:0] KEY_SHIFT [ROUNDS] = '{
        1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28 };

    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    // Initial permutation; table entries count bits from the MSB, starting at 1.
    function automatic logic [BLOCK_BITS-1:0] perm_ip(input logic [BLOCK_BITS-1:0] v);
        logic [BLOCK_BITS-1:0] r;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            r[BLOCK_BITS-1-i] = v[BLOCK_BITS - int'(TAB_IP[i])];
        end
        return r;
    endfunction

    // Inverse initial permutation.
    function automatic logic [BLOCK_BITS-1:0] perm_fp(input logic [BLOCK_BITS-1:0] v);
        logic [BLOCK_BITS-1:0] r;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            r[BLOCK_BITS-1-i] = v[BLOCK_BITS - int'(TAB_FP[i])];
        end
        return r;
    endfunction

    // Round function: expansion, key mix, S-boxes and the P permutation.
    function automatic logic [HALF_BLOCK_BITS-1:0] feistel(
        input logic [HALF_BLOCK_BITS-1:0] rh,
        input t_round_key                 k
    );
        logic [ROUND_KEY_BITS-1:0]  x;
        logic [5:0]                 six;
        logic [HALF_BLOCK_BITS-1:0] s;
        logic [HALF_BLOCK_BITS-1:0] r;
        for (int i = 0; i < ROUND_KEY_BITS; i++) begin
            x[ROUND_KEY_BITS-1-i] = rh[HALF_BLOCK_BITS - int'(TAB_E[i])];
        end
        x = x ^ k;
        for (int b = 0; b < 8; b++) begin
            six = x[ROUND_KEY_BITS-1-6*b -: 6];
            s[HALF_BLOCK_BITS-1-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < HALF_BLOCK_BITS; i++) begin
            r[HALF_BLOCK_BITS-1-i] = s[HALF_BLOCK_BITS - int'(TAB_P[i])];
        end
        return r;
    endfunction

    // Round key of a given round: PC-1, total rotation up to that round, PC-2.
    // For a constant round this is pure wiring of the key.
    function automatic t_round_key round_key(
        input logic [BLOCK_BITS-1:0] key,
        input logic [3:0]            rnd
    );
        logic [2*HALF_KEY_BITS-1:0] cd;
        logic [HALF_KEY_BITS-1:0]   c;
        logic [HALF_KEY_BITS-1:0]   d;
        logic [4:0]                 sh;
        t_round_key                 r;
        for (int i = 0; i < 2*HALF_KEY_BITS; i++) begin
            cd[2*HALF_KEY_BITS-1-i] = key[BLOCK_BITS - int'(TAB_PC1[i])];
        end
        sh = KEY_SHIFT[rnd];
        c  = cd[2*HALF_KEY_BITS-1:HALF_KEY_BITS];
        d  = cd[HALF_KEY_BITS-1:0];
        c  = (c << sh) | (c >> (5'(HALF_KEY_BITS) - sh));
        d  = (d << sh) | (d >> (5'(HALF_KEY_BITS) - sh));
        cd = {c, d};
        for (int i = 0; i < ROUND_KEY_BITS; i++) begin
            r[ROUND_KEY_BITS-1-i] = cd[2*HALF_KEY_BITS - int'(TAB_PC2[i])];
        end
        return r;
    endfunction

endpackage

>>> src/des_ifs.sv
// Handshake interfaces for the plaintext and ciphertext channels.
// Depends on des_pkg for the block width.
interface des_plain_if;
    logic                              valid;
    logic                              ready;
    logic [des_pkg::BLOCK_BITS-1:0]    plain_block;

    modport source (output valid, output plain_block, input ready);
    modport sink   (input valid, input plain_block, output ready);
endinterface

interface des_cipher_if;
    logic                              valid;
    logic                              ready;
    logic [des_pkg::BLOCK_BITS-1:0]    cipher_block;

    modport source (output valid, output cipher_block, input ready);
    modport sink   (input valid, input cipher_block, output ready);
endinterface

>>> src/des_cell.sv
// One DES round cell: a registered pipeline stage that applies a single Feistel round.
// Depends on des_pkg and des_block_encrypt_macros.svh.
`include "des_block_encrypt_macros.svh"

module des_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_up_valid,
    output logic               o_up_ready,
    input  des_pkg::t_halves   i_up_data,
    input  des_pkg::t_round_key i_subkey,
    output logic               o_down_valid,
    input  logic               i_down_ready,
    output des_pkg::t_halves   o_down_data
);
    import des_pkg::*;

    logic    r_valid;
    t_halves r_data;
    t_halves n_data;
    logic    w_load;

    // The stage takes a new request when it is empty or its content moves on.
    assign o_up_ready = !r_valid || i_down_ready;
    assign w_load     = i_up_valid && o_up_ready;

    // Feistel round: the new left half is the old right half.
    always_comb begin
        n_data.left  = i_up_data.right;
        n_data.right = i_up_data.left ^ feistel(i_up_data.right, i_subkey);
    end

    // Occupancy of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    // Round data, loaded only with a request.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_down_valid = r_valid;
    assign o_down_data  = r_data;

    `DES_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> !r_valid)
    `DES_ASSERT(a_hold_when_stalled, i_clk, i_rst_n,
        r_valid && !i_down_ready |=> r_valid && $stable(r_data))
    `DES_ASSERT(a_load_fills, i_clk, i_rst_n, w_load |=> r_valid)

endmodule

>>> src/des_block_encrypt.sv
// Top level of the DES encryption block: key register, initial and final
// permutations around a chain of sixteen round cells. Depends on des_pkg, des_ifs, des_cell.

// DES encryption of 64-bit blocks (ECB) under the key held in a 64-bit register.
// One request is accepted per cycle while the first round cell is ready; each block
// passes through sixteen registered round cells, one Feistel round each. Each cell
// stalls on its own, so bubbles close up while the output is held. The round keys
// are wired from the key register (PC-1, fixed rotation, PC-2 per round); a key write
// takes effect at the next request and must only be made while no block is in flight.
module des_block_encrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    des_plain_if.sink                      i_plain,
    des_cipher_if.source                   o_cipher,
    input  logic                           i_key_we,
    input  logic [des_pkg::BLOCK_BITS-1:0] i_key_data
);
    import des_pkg::*;

    logic [BLOCK_BITS-1:0] r_key;
    logic [BLOCK_BITS-1:0] w_ip;
    logic                  w_valid [ROUNDS+1];
    logic                  w_ready [ROUNDS+1];
    t_halves               w_data  [ROUNDS+1];
    t_halves               w_last;

    // Key register, cleared to the all-zero key at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_key_we) begin
            r_key <= i_key_data;
        end
    end

    // Input side: initial permutation feeds the first cell.
    assign w_ip            = perm_ip(i_plain.plain_block);
    assign w_valid[0]      = i_plain.valid;
    assign i_plain.ready   = w_ready[0];
    assign w_data[0].left  = w_ip[BLOCK_BITS-1:HALF_BLOCK_BITS];
    assign w_data[0].right = w_ip[HALF_BLOCK_BITS-1:0];

    // Chain of round cells.
    for (genvar k = 0; k < ROUNDS; k++) begin : g_round
        des_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_up_valid   (w_valid[k]),
            .o_up_ready   (w_ready[k]),
            .i_up_data    (w_data[k]),
            .i_subkey     (round_key(r_key, 4'(k))),
            .o_down_valid (w_valid[k+1]),
            .i_down_ready (w_ready[k+1]),
            .o_down_data  (w_data[k+1])
        );
    end

    // Output side: swap the halves and apply the inverse permutation.
    assign w_last                = w_data[ROUNDS];
    assign o_cipher.valid        = w_valid[ROUNDS];
    assign w_ready[ROUNDS]       = o_cipher.ready;
    assign o_cipher.cipher_block = perm_fp({w_last.right, w_last.left});

endmodule

>>> sim/des_block_encrypt_tb.sv
// Testbench for des_block_encrypt: encrypts directed and random blocks under several keys and
// checks every ciphertext against a bit-level DES model kept in the testbench.
// Depends on des_pkg (tables, widths) and des_ifs (channel interfaces) from the RTL.
module des_block_encrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import des_pkg::*;

    // Cycles without any accepted request or result before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Round-cell depth plus margin, waited out after the last result.
    localparam int TAIL_CYCLES    = 32;
    localparam int BACKPRESSURE   = 120;
    localparam int RANDOM_PHASES  = 10;
    localparam int RANDOM_BLOCKS  = 103;
    localparam int MAX_REPORTS    = 10;

    // Left rotation of C and D in each round of the key schedule.
    localparam int KEY_ROT [ROUNDS] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  key_we;
    logic [BLOCK_BITS-1:0] key_data;

    des_plain_if  plain_ch ();
    des_cipher_if cipher_ch ();

    des_block_encrypt u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_plain    (plain_ch),
        .o_cipher   (cipher_ch),
        .i_key_we   (key_we),
        .i_key_data (key_data)
    );

    t_round_key            sched_keys [ROUNDS];
    logic [BLOCK_BITS-1:0] plain_jobs_q [$];
    logic [BLOCK_BITS-1:0] cipher_exp_q [$];
    int                    error_cnt;
    int                    blocks_in;
    int                    cycle_no;
    int                    quiet_cycles;
    int                    hold_left;
    bit                    pressure_done;
    logic                  plain_taken;

    // Idle-free window on both channels.
    wire calm = (cycle_no >= 300) && (cycle_no < 900);

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Derive the sixteen round keys: PC-1, per-round rotation of the halves, PC-2.
    function automatic void expand_key_schedule(input logic [BLOCK_BITS-1:0] key);
        logic [2*HALF_KEY_BITS-1:0] cd;
        logic [HALF_KEY_BITS-1:0]   c;
        logic [HALF_KEY_BITS-1:0]   d;
        t_round_key                 k;
        for (int i = 0; i < 2*HALF_KEY_BITS; i++) begin
            cd[2*HALF_KEY_BITS-1-i] = key[BLOCK_BITS - int'(TAB_PC1[i])];
        end
        c = cd[2*HALF_KEY_BITS-1:HALF_KEY_BITS];
        d = cd[HALF_KEY_BITS-1:0];
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            for (int s = 0; s < KEY_ROT[rnd]; s++) begin
                c = {c[HALF_KEY_BITS-2:0], c[HALF_KEY_BITS-1]};
                d = {d[HALF_KEY_BITS-2:0], d[HALF_KEY_BITS-1]};
            end
            cd = {c, d};
            for (int i = 0; i < ROUND_KEY_BITS; i++) begin
                k[ROUND_KEY_BITS-1-i] = cd[2*HALF_KEY_BITS - int'(TAB_PC2[i])];
            end
            sched_keys[rnd] = k;
        end
    endfunction

    // Full DES encryption of one block under the current round keys.
    function automatic logic [BLOCK_BITS-1:0] des_encrypt_block(
        input logic [BLOCK_BITS-1:0] blk
    );
        logic [BLOCK_BITS-1:0]      v;
        logic [BLOCK_BITS-1:0]      res;
        logic [HALF_BLOCK_BITS-1:0] lh;
        logic [HALF_BLOCK_BITS-1:0] rh;
        logic [HALF_BLOCK_BITS-1:0] sb;
        logic [HALF_BLOCK_BITS-1:0] f;
        logic [ROUND_KEY_BITS-1:0]  x;
        logic [5:0]                 six;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            v[BLOCK_BITS-1-i] = blk[BLOCK_BITS - int'(TAB_IP[i])];
        end
        lh = v[BLOCK_BITS-1:HALF_BLOCK_BITS];
        rh = v[HALF_BLOCK_BITS-1:0];
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            for (int i = 0; i < ROUND_KEY_BITS; i++) begin
                x[ROUND_KEY_BITS-1-i] = rh[HALF_BLOCK_BITS - int'(TAB_E[i])];
            end
            x = x ^ sched_keys[rnd];
            for (int b = 0; b < 8; b++) begin
                six = x[ROUND_KEY_BITS-1-6*b -: 6];
                sb[HALF_BLOCK_BITS-1-4*b -: 4] =
                    SBOX[b][int'({six[5], six[0]}) * 16 + int'(six[4:1])];
            end
            for (int i = 0; i < HALF_BLOCK_BITS; i++) begin
                f[HALF_BLOCK_BITS-1-i] = sb[HALF_BLOCK_BITS - int'(TAB_P[i])];
            end
            f  = f ^ lh;
            lh = rh;
            rh = f;
        end
        // Halves are swapped after the last round, then IP inverse.
        v = {rh, lh};
        for (int i = 0; i < BLOCK_BITS; i++) begin
            res[BLOCK_BITS-1-i] = v[BLOCK_BITS - int'(TAB_FP[i])];
        end
        return res;
    endfunction

    function automatic void note_mismatch(
        input string                 what,
        input logic [BLOCK_BITS-1:0] exp_val,
        input logic [BLOCK_BITS-1:0] act_val
    );
        error_cnt++;
        if (error_cnt <= MAX_REPORTS) begin
            $display("ERROR %s: expected %016h, got %016h", what, exp_val, act_val);
        end
    endfunction

    // Mostly uniform blocks, with some extremes and single-bit patterns mixed in.
    function automatic logic [BLOCK_BITS-1:0] pick_plain();
        logic [BLOCK_BITS-1:0] blk;
        case ($urandom_range(15))
            0: begin
                blk = '0;
            end
            1: begin
                blk = '1;
            end
            2: begin
                blk = '0;
                blk[$urandom_range(BLOCK_BITS-1)] = 1'b1;
            end
            3: begin
                blk = '1;
                blk[$urandom_range(BLOCK_BITS-1)] = 1'b0;
            end
            default: begin
                blk = {$urandom, $urandom};
            end
        endcase
        return blk;
    endfunction

    // Wait until no request is pending, offered or in flight.
    task automatic drain_pipeline();
        while (plain_jobs_q.size() != 0 || plain_ch.valid || cipher_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Key writes only happen with the pipeline empty.
    task automatic load_key(input logic [BLOCK_BITS-1:0] key);
        drain_pipeline();
        @(negedge i_clk);
        key_we   <= 1'b1;
        key_data <= key;
        expand_key_schedule(key);
        @(negedge i_clk);
        key_we   <= 1'b0;
    endtask

    // Request driver: a new block is offered once the previous one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            plain_ch.valid       <= 1'b0;
            plain_ch.plain_block <= '0;
        end else if (!plain_ch.valid || plain_taken) begin
            if (plain_jobs_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
                plain_ch.valid       <= 1'b1;
                plain_ch.plain_block <= plain_jobs_q.pop_front();
            end else begin
                plain_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off to fill the round cells.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cipher_ch.ready <= 1'b0;
            hold_left       <= 0;
            pressure_done   <= 1'b0;
        end else if (hold_left > 0) begin
            cipher_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (!pressure_done && blocks_in >= 400) begin
            cipher_ch.ready <= 1'b0;
            hold_left       <= BACKPRESSURE;
            pressure_done   <= 1'b1;
        end else begin
            cipher_ch.ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    // Monitor: predicts on each accepted request, checks each accepted result in order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plain_taken  <= 1'b0;
            quiet_cycles <= 0;
            cycle_no     <= 0;
        end else begin
            cycle_no    <= cycle_no + 1;
            plain_taken <= plain_ch.valid && plain_ch.ready;
            if (cipher_ch.valid && cipher_ch.ready) begin
                if (cipher_exp_q.size() == 0) begin
                    note_mismatch("result with no request pending", 'x, cipher_ch.cipher_block);
                end else if (cipher_ch.cipher_block !== cipher_exp_q[0]) begin
                    note_mismatch("cipher_block", cipher_exp_q[0], cipher_ch.cipher_block);
                    void'(cipher_exp_q.pop_front());
                end else begin
                    void'(cipher_exp_q.pop_front());
                end
            end
            if (plain_ch.valid && plain_ch.ready) begin
                cipher_exp_q.push_back(des_encrypt_block(plain_ch.plain_block));
                blocks_in <= blocks_in + 1;
            end
            // Watchdog on progress of either channel or the key port.
            if ((plain_ch.valid && plain_ch.ready) || (cipher_ch.valid && cipher_ch.ready)
                    || key_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("des_block_encrypt: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus sequence: directed blocks under fixed keys, then random phases.
    initial begin
        logic [BLOCK_BITS-1:0] phase_key;
        i_rst_n              = 1'b0;
        key_we               = 1'b0;
        key_data             = '0;
        plain_ch.valid       = 1'b0;
        plain_ch.plain_block = '0;
        cipher_ch.ready      = 1'b0;
        error_cnt            = 0;
        blocks_in            = 0;
        cycle_no             = 0;
        expand_key_schedule('0);

        // Known-answer sanity check of the model under the all-zero key.
        if (des_encrypt_block('0) !== 64'h8CA6_4DE9_C1B1_23A7) begin
            note_mismatch("model, zero key", 64'h8CA6_4DE9_C1B1_23A7, des_encrypt_block('0));
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Key after reset is zero, so all round keys are zero.
        plain_jobs_q.push_back('0);
        plain_jobs_q.push_back('1);
        plain_jobs_q.push_back(64'h0123_4567_89AB_CDEF);
        plain_jobs_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        plain_jobs_q.push_back(64'h5555_5555_5555_5555);
        plain_jobs_q.push_back(64'h8000_0000_0000_0000);
        plain_jobs_q.push_back(64'h0000_0000_0000_0001);

        // Textbook key, with a known ciphertext for the model.
        load_key(64'h1334_5779_9BBC_DFF1);
        if (des_encrypt_block(64'h0123_4567_89AB_CDEF) !== 64'h85E8_1354_0F0A_B405) begin
            note_mismatch("model, textbook key", 64'h85E8_1354_0F0A_B405,
                          des_encrypt_block(64'h0123_4567_89AB_CDEF));
        end
        plain_jobs_q.push_back(64'h0123_4567_89AB_CDEF);
        plain_jobs_q.push_back('0);
        plain_jobs_q.push_back('1);

        load_key('1);
        plain_jobs_q.push_back('0);
        plain_jobs_q.push_back('1);
        plain_jobs_q.push_back(64'h0123_4567_89AB_CDEF);

        // Weak key: only parity bits set, so the schedule equals that of the zero key.
        load_key(64'h0101_0101_0101_0101);
        plain_jobs_q.push_back('0);
        plain_jobs_q.push_back('1);

        // Weak key with all non-parity bits set.
        load_key(64'hFEFE_FEFE_FEFE_FEFE);
        plain_jobs_q.push_back('0);
        plain_jobs_q.push_back(64'h0123_4567_89AB_CDEF);

        // Semi-weak key.
        load_key(64'h01FE_01FE_01FE_01FE);
        plain_jobs_q.push_back(64'hDEAD_BEEF_0BAD_F00D);

        // Random phases; the first and last use the extreme keys.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                phase_key = '0;
            end else if (p == RANDOM_PHASES - 1) begin
                phase_key = '1;
            end else begin
                phase_key = {$urandom, $urandom};
            end
            load_key(phase_key);
            for (int n = 0; n < RANDOM_BLOCKS; n++) begin
                plain_jobs_q.push_back(pick_plain());
            end
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && cipher_exp_q.size() == 0) begin
            $display("des_block_encrypt: match");
        end else begin
            $display("des_block_encrypt: mismatch");
        end
        $finish;
    end

endmodule
